[rtl/core/bpyc_pkg.sv]
// shared types, constants and helpers for the bmp pixel to ycbcr unit
package bpyc_pkg;

  // configuration register file
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_W      = 13;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BOTTOM_UP    = 2'd2;
  localparam logic [1:0] REG_PIXEL_32BIT  = 2'd3;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic             RST_BOTTOM_UP    = 1'b1;
  localparam logic             RST_PIXEL_32BIT  = 1'b0;

  // default size limits
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // output position fields
  localparam int POS_W = 12;

  // q16 color matrix, jfif full range
  localparam int ACC_W = 27;
  localparam logic signed [ACC_W-1:0] Y_R     = 27'sd19595;
  localparam logic signed [ACC_W-1:0] Y_G     = 27'sd38470;
  localparam logic signed [ACC_W-1:0] Y_B     = 27'sd7471;
  localparam logic signed [ACC_W-1:0] CB_R    = 27'sd11056;
  localparam logic signed [ACC_W-1:0] CB_G    = 27'sd21712;
  localparam logic signed [ACC_W-1:0] CB_B    = 27'sd32768;
  localparam logic signed [ACC_W-1:0] CR_R    = 27'sd32768;
  localparam logic signed [ACC_W-1:0] CR_G    = 27'sd27440;
  localparam logic signed [ACC_W-1:0] CR_B    = 27'sd5328;
  localparam logic signed [ACC_W-1:0] C_OFFS  = 27'sd8388608;

  // byte position within a stored pixel
  typedef enum logic [3:0] {
    PH_BLUE  = 4'b0001,
    PH_GREEN = 4'b0010,
    PH_RED   = 4'b0100,
    PH_ALPHA = 4'b1000
  } phase_t;

  // live configuration
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             bottom_up;
    logic             is_32bit;
  } cfg_t;

  // one assembled pixel with its position
  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             done;
  } pixel_t;

  // floor by 2^16, then clamp to 0..255
  function automatic logic [7:0] to_byte(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-17:0] v;
    v = acc[ACC_W-1:16];
    if (acc < 0) begin
      return 8'd0;
    end else if (v > 11'd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

endpackage

[rtl/core/bpyc_parse.sv]
// byte stream parser: phase, padding, row and column counters, pixel register
module bpyc_parse #(
  parameter int MAX_WIDTH  = bpyc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bpyc_pkg::DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bpyc_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              pix_valid,
  input  logic              pix_ready,
  output bpyc_pkg::pixel_t  pix
);

  localparam int DW   = bpyc_pkg::DIM_W;
  localparam int DMAX = (1 << DW) - 1;
  localparam int WLIM = (MAX_WIDTH < DMAX) ? MAX_WIDTH : DMAX;
  localparam int HLIM = (MAX_HEIGHT < DMAX) ? MAX_HEIGHT : DMAX;
  localparam int CW   = (WLIM > 1) ? $clog2(WLIM) : 1;
  localparam int RW   = (HLIM > 1) ? $clog2(HLIM) : 1;

  bpyc_pkg::phase_t  phase_r, phase_nxt;
  logic [1:0]        pad_r, pad_nxt;
  logic [7:0]        blue_r, blue_nxt;
  logic [7:0]        green_r, green_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic              pix_v_r, pix_v_nxt;
  bpyc_pkg::pixel_t  pix_r, pix_nxt;

  logic              fire;
  logic              emit;
  logic [DW-1:0]     w_eff, h_eff;
  logic [DW-1:0]     col_cnt, row_cnt;
  logic [DW-1:0]     col_cur, row_cur, orow;
  logic              last_col, last_row;

  assign in_ready  = !pix_v_r || pix_ready;
  assign fire      = in_valid && in_ready;
  assign pix_valid = pix_v_r;
  assign pix       = pix_r;

  // effective image size: zero reads as one, oversize reads as the limit
  always_comb begin
    if (cfg.width == '0) begin
      w_eff = DW'(1);
    end else if (32'(cfg.width) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = cfg.width;
    end
    if (cfg.height == '0) begin
      h_eff = DW'(1);
    end else if (32'(cfg.height) > MAX_HEIGHT) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = cfg.height;
    end
  end

  // position of the current pixel, pulled back inside a lowered bound
  assign col_cnt  = DW'(col_r);
  assign row_cnt  = DW'(row_r);
  assign col_cur  = (col_cnt < w_eff) ? col_cnt : w_eff - DW'(1);
  assign row_cur  = (row_cnt < h_eff) ? row_cnt : h_eff - DW'(1);
  assign orow     = cfg.bottom_up ? (h_eff - DW'(1) - row_cur) : row_cur;
  assign last_col = (col_cur == w_eff - DW'(1));
  assign last_row = (row_cur == h_eff - DW'(1));

  // byte sequencing and counters
  always_comb begin
    phase_nxt = phase_r;
    pad_nxt   = pad_r;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    emit      = 1'b0;
    if (fire) begin
      if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
      end else begin
        unique case (phase_r)
          bpyc_pkg::PH_BLUE: begin
            blue_nxt  = in_byte;
            phase_nxt = bpyc_pkg::PH_GREEN;
          end
          bpyc_pkg::PH_GREEN: begin
            green_nxt = in_byte;
            phase_nxt = bpyc_pkg::PH_RED;
          end
          bpyc_pkg::PH_RED: begin
            emit      = 1'b1;
            phase_nxt = cfg.is_32bit ? bpyc_pkg::PH_ALPHA : bpyc_pkg::PH_BLUE;
            if (last_col) begin
              col_nxt = '0;
              if (!cfg.is_32bit) begin
                pad_nxt = w_eff[1:0];
              end
              row_nxt = last_row ? '0 : RW'(row_cur + DW'(1));
            end else begin
              col_nxt = CW'(col_cur + DW'(1));
              row_nxt = RW'(row_cur);
            end
          end
          bpyc_pkg::PH_ALPHA: begin
            phase_nxt = bpyc_pkg::PH_BLUE;
          end
          default: begin
            phase_nxt = bpyc_pkg::PH_BLUE;
          end
        endcase
      end
    end
  end

  // pixel register toward the converter
  always_comb begin
    pix_nxt   = pix_r;
    pix_v_nxt = pix_v_r;
    if (emit) begin
      pix_v_nxt      = 1'b1;
      pix_nxt.red    = in_byte;
      pix_nxt.green  = green_r;
      pix_nxt.blue   = blue_r;
      pix_nxt.row    = orow[bpyc_pkg::POS_W-1:0];
      pix_nxt.column = col_cur[bpyc_pkg::POS_W-1:0];
      pix_nxt.done   = last_col && last_row;
    end else if (pix_ready) begin
      pix_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bpyc_pkg::PH_BLUE;
      pad_r   <= '0;
      blue_r  <= '0;
      green_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      pix_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pad_r   <= pad_nxt;
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pix_v_r <= pix_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  // padding only ever follows a finished 24-bit row
  a_pad_phase: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r != 2'd0 |-> phase_r == bpyc_pkg::PH_BLUE)
    else $error("padding pending outside the blue phase");

  // a red byte always leaves a pixel waiting
  a_red_emits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && pad_r == 2'd0 && phase_r == bpyc_pkg::PH_RED |=> pix_v_r)
    else $error("red byte produced no pixel");

  // counters restart after the last pixel of an image
  a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    emit && last_col && last_row |=> col_r == '0 && row_r == '0)
    else $error("counters did not restart at end of image");

endmodule

[rtl/core/bpyc_conv.sv]
// q16 rgb to ycbcr matrix and the result register
module bpyc_conv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  bpyc_pkg::pixel_t               pix,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_luma,
  output logic [7:0]                     out_chroma_blue,
  output logic [7:0]                     out_chroma_red,
  output logic [bpyc_pkg::POS_W-1:0]     out_row,
  output logic [bpyc_pkg::POS_W-1:0]     out_column,
  output logic                           out_image_done
);

  localparam int AW = bpyc_pkg::ACC_W;

  logic signed [AW-1:0] rs, gs, bs;
  logic signed [AW-1:0] acc_y, acc_cb, acc_cr;

  logic                           out_v_r, out_v_nxt;
  logic [7:0]                     y_r, cb_r, cr_r;
  logic [bpyc_pkg::POS_W-1:0]     row_r, col_r;
  logic                           done_r;

  // constant-coefficient products and sums
  assign rs = $signed(AW'(pix.red));
  assign gs = $signed(AW'(pix.green));
  assign bs = $signed(AW'(pix.blue));

  assign acc_y  = bpyc_pkg::Y_R * rs + bpyc_pkg::Y_G * gs + bpyc_pkg::Y_B * bs;
  assign acc_cb = bpyc_pkg::C_OFFS - bpyc_pkg::CB_R * rs - bpyc_pkg::CB_G * gs
                + bpyc_pkg::CB_B * bs;
  assign acc_cr = bpyc_pkg::C_OFFS + bpyc_pkg::CR_R * rs - bpyc_pkg::CR_G * gs
                - bpyc_pkg::CR_B * bs;

  // result register handshake
  assign pix_ready = !out_v_r || out_ready;
  assign out_v_nxt = pix_valid ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      y_r    <= bpyc_pkg::to_byte(acc_y);
      cb_r   <= bpyc_pkg::to_byte(acc_cb);
      cr_r   <= bpyc_pkg::to_byte(acc_cr);
      row_r  <= pix.row;
      col_r  <= pix.column;
      done_r <= pix.done;
    end
  end

  assign out_valid       = out_v_r;
  assign out_luma        = y_r;
  assign out_chroma_blue = cb_r;
  assign out_chroma_red  = cr_r;
  assign out_row         = row_r;
  assign out_column      = col_r;
  assign out_image_done  = done_r;

endmodule

[rtl/core/bmp_pixel_to_ycbcr_unit.sv]
// top level: register file, byte parser and color converter
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_ready  | in_pixel_byte[7:0]
//  out     | source    | out_valid/out_ready| luma, chroma_blue, chroma_red, row, column, done
//  cfg     | apb slave | psel/penable/pready| paddr[3:0], pwdata, prdata
//
// one byte is taken per cycle while in_ready is high; a red byte gives a pixel by way of the
// pixel register, then the result register after the color matrix
// synchronous active-low reset clears counters and valids, registers go to 640/480/1/0
// a stalled result holds the pipeline; in_ready drops only while both stages are full
module bmp_pixel_to_ycbcr_unit #(
  parameter int MAX_WIDTH  = bpyc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bpyc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpyc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bpyc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bpyc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_pixel_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_luma,
  output logic [7:0]                          out_chroma_blue,
  output logic [7:0]                          out_chroma_red,
  output logic [bpyc_pkg::POS_W-1:0]          out_row,
  output logic [bpyc_pkg::POS_W-1:0]          out_column,
  output logic                                out_image_done
);

  localparam int DW = bpyc_pkg::DIM_W;
  localparam int XW = bpyc_pkg::CFG_DATA_W;

  bpyc_pkg::cfg_t    cfg_r, cfg_nxt;
  logic              cfg_wr;
  logic [1:0]        reg_sel;
  logic              pix_valid;
  logic              pix_ready;
  bpyc_pkg::pixel_t  pix;

  // register file write
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        bpyc_pkg::REG_IMAGE_WIDTH:  cfg_nxt.width     = pwdata[DW-1:0];
        bpyc_pkg::REG_IMAGE_HEIGHT: cfg_nxt.height    = pwdata[DW-1:0];
        bpyc_pkg::REG_BOTTOM_UP:    cfg_nxt.bottom_up = pwdata[0];
        bpyc_pkg::REG_PIXEL_32BIT:  cfg_nxt.is_32bit  = pwdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width     <= bpyc_pkg::RST_IMAGE_WIDTH;
      cfg_r.height    <= bpyc_pkg::RST_IMAGE_HEIGHT;
      cfg_r.bottom_up <= bpyc_pkg::RST_BOTTOM_UP;
      cfg_r.is_32bit  <= bpyc_pkg::RST_PIXEL_32BIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register file read
  always_comb begin
    unique case (reg_sel)
      bpyc_pkg::REG_IMAGE_WIDTH:  prdata = XW'(cfg_r.width);
      bpyc_pkg::REG_IMAGE_HEIGHT: prdata = XW'(cfg_r.height);
      bpyc_pkg::REG_BOTTOM_UP:    prdata = XW'(cfg_r.bottom_up);
      bpyc_pkg::REG_PIXEL_32BIT:  prdata = XW'(cfg_r.is_32bit);
      default:                    prdata = '0;
    endcase
  end

  // byte parser and pixel register
  bpyc_parse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_pixel_byte),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  // color matrix and result register
  bpyc_conv u_conv (
    .clk             (clk),
    .rst_n           (rst_n),
    .pix_valid       (pix_valid),
    .pix_ready       (pix_ready),
    .pix             (pix),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_luma        (out_luma),
    .out_chroma_blue (out_chroma_blue),
    .out_chroma_red  (out_chroma_red),
    .out_row         (out_row),
    .out_column      (out_column),
    .out_image_done  (out_image_done)
  );

endmodule

[test/tb_bmp_pixel_to_ycbcr_unit.sv]
// testbench for the bmp pixel to ycbcr unit: byte streams checked against a pixel predictor
`timescale 1ns / 100ps

module tb_bmp_pixel_to_ycbcr_unit;

  localparam int MAX_W        = bpyc_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H        = bpyc_pkg::DEF_MAX_HEIGHT;
  localparam int POS_W        = bpyc_pkg::POS_W;
  localparam int DIM_W        = bpyc_pkg::DIM_W;
  localparam int CFG_ADDR_W   = bpyc_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W   = bpyc_pkg::CFG_DATA_W;
  localparam int ITEM_TARGET  = 1350;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;

  // q16 color matrix, jfif full range
  localparam int KY_R  = 19595;
  localparam int KY_G  = 38470;
  localparam int KY_B  = 7471;
  localparam int KCB_R = 11056;
  localparam int KCB_G = 21712;
  localparam int KCB_B = 32768;
  localparam int KCR_R = 32768;
  localparam int KCR_G = 27440;
  localparam int KCR_B = 5328;
  localparam int C_MID = 128 * 65536;

  // one converted pixel as the result channel carries it
  typedef struct packed {
    logic [7:0]       luma;
    logic [7:0]       chroma_blue;
    logic [7:0]       chroma_red;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             done;
  } ycc_pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_pixel_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_luma;
  logic [7:0]            out_chroma_blue;
  logic [7:0]            out_chroma_red;
  logic [POS_W-1:0]      out_row;
  logic [POS_W-1:0]      out_column;
  logic                  out_image_done;

  // predictor copy of the registers and the parser state
  bpyc_pkg::cfg_t   live_cfg;
  bpyc_pkg::phase_t byte_pos;
  logic [7:0]       held_b;
  logic [7:0]       held_g;
  logic [POS_W-1:0] col_cnt;
  logic [POS_W-1:0] row_cnt;
  logic [1:0]       pad_left;

  logic [7:0]       pending_bytes[$];
  ycc_pixel_t       expected_pixels[$];
  int               error_count = 0;
  int               cycle_count = 0;
  int               sender_idle_pct = 0;
  int               receiver_idle_pct = 0;

  bmp_pixel_to_ycbcr_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_byte  (in_pixel_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_luma       (out_luma),
    .out_chroma_blue(out_chroma_blue),
    .out_chroma_red (out_chroma_red),
    .out_row        (out_row),
    .out_column     (out_column),
    .out_image_done (out_image_done)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // zero counts as one, oversize counts as the limit
  function automatic int unsigned clip_dim(input logic [DIM_W-1:0] v, input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  // floor by 2^16 and clamp to a byte
  function automatic logic [7:0] to_component(input int acc);
    int q;
    if (acc < 0) return 8'd0;
    q = acc / 65536;
    return (q > 255) ? 8'd255 : 8'(q);
  endfunction

  // advance the parser by one byte, queue a pixel on a red byte
  task automatic absorb_byte(input logic [7:0] b);
    int unsigned w, h, col, row;
    int          r, g, bl;
    logic        last_col, last_row;
    ycc_pixel_t  px;
    if (pad_left != 2'd0) begin
      pad_left = pad_left - 2'd1;
    end else if (byte_pos == bpyc_pkg::PH_BLUE) begin
      held_b = b;
      byte_pos = bpyc_pkg::PH_GREEN;
    end else if (byte_pos == bpyc_pkg::PH_GREEN) begin
      held_g = b;
      byte_pos = bpyc_pkg::PH_RED;
    end else if (byte_pos == bpyc_pkg::PH_ALPHA) begin
      byte_pos = bpyc_pkg::PH_BLUE;
    end else begin
      w = clip_dim(live_cfg.width, MAX_W);
      h = clip_dim(live_cfg.height, MAX_H);
      // a counter past a lowered bound ends its row or image
      col = (col_cnt < w) ? col_cnt : w - 1;
      row = (row_cnt < h) ? row_cnt : h - 1;
      r = b;
      g = held_g;
      bl = held_b;
      px.luma        = to_component(KY_R * r + KY_G * g + KY_B * bl);
      px.chroma_blue = to_component(C_MID - KCB_R * r - KCB_G * g + KCB_B * bl);
      px.chroma_red  = to_component(C_MID + KCR_R * r - KCR_G * g - KCR_B * bl);
      px.row         = POS_W'(live_cfg.bottom_up ? (h - 1 - row) : row);
      px.column      = POS_W'(col);
      last_col = (col + 1 >= w);
      last_row = (row + 1 >= h);
      px.done = last_col && last_row;
      expected_pixels.push_back(px);
      if (live_cfg.is_32bit) begin
        byte_pos = bpyc_pkg::PH_ALPHA;
      end else begin
        byte_pos = bpyc_pkg::PH_BLUE;
      end
      if (last_col) begin
        col_cnt = '0;
        if (!live_cfg.is_32bit) pad_left = 2'(w);
        row_cnt = last_row ? '0 : POS_W'(row + 1);
      end else begin
        col_cnt = POS_W'(col + 1);
        row_cnt = POS_W'(row);
      end
    end
  endtask

  // byte stream driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      byte_pos = bpyc_pkg::PH_BLUE;
      held_b = '0;
      held_g = '0;
      col_cnt = '0;
      row_cnt = '0;
      pad_left = '0;
    end else begin
      if (in_valid && in_ready) absorb_byte(in_pixel_byte);
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_pixel_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin : result_monitor
    ycc_pixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel with none expected: row %0d column %0d", out_row, out_column);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          compare_field("luma", want.luma, out_luma);
          compare_field("chroma_blue", want.chroma_blue, out_chroma_blue);
          compare_field("chroma_red", want.chroma_red, out_chroma_red);
          compare_field("out_row", want.row, out_row);
          compare_field("out_column", want.column, out_column);
          compare_field("image_done", want.done, out_image_done);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // apb write; upper data bits are random and must be ignored
  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    if (idx == bpyc_pkg::REG_IMAGE_WIDTH || idx == bpyc_pkg::REG_IMAGE_HEIGHT) begin
      word[DIM_W-1:0] = value;
    end else begin
      word[0] = value[0];
    end
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      bpyc_pkg::REG_IMAGE_WIDTH:  live_cfg.width = word[DIM_W-1:0];
      bpyc_pkg::REG_IMAGE_HEIGHT: live_cfg.height = word[DIM_W-1:0];
      bpyc_pkg::REG_BOTTOM_UP:    live_cfg.bottom_up = word[0];
      bpyc_pkg::REG_PIXEL_32BIT:  live_cfg.is_32bit = word[0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mask bits: width, height, bottom_up, 32-bit
  task automatic apply_setting(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic bu, input logic b32, input logic [3:0] mask);
    if (mask[0]) write_reg(bpyc_pkg::REG_IMAGE_WIDTH, w);
    if (mask[1]) write_reg(bpyc_pkg::REG_IMAGE_HEIGHT, h);
    if (mask[2]) write_reg(bpyc_pkg::REG_BOTTOM_UP, DIM_W'(bu));
    if (mask[3]) write_reg(bpyc_pkg::REG_PIXEL_32BIT, DIM_W'(b32));
  endtask

  // wait until every queued byte is taken and every pixel has come out
  // checked on the falling edge, once the driver's updates have settled
  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    pending_bytes.push_back(b);
    pending_bytes.push_back(g);
    pending_bytes.push_back(r);
  endtask

  // mostly small sizes, now and then zero or oversize
  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return DIM_W'($urandom_range(1, 6));
    if (sel < 14) return DIM_W'($urandom_range(7, 40));
    if (sel == 14) return '0;
    if (sel == 15) return DIM_W'(MAX_W);
    if (sel == 16) return '1;
    if (sel == 17) return DIM_W'(MAX_W - 1);
    if (sel == 18) return DIM_W'($urandom_range(MAX_W + 1, 8190));
    return DIM_W'($urandom);
  endfunction

  // color bytes with extra weight on the extremes
  function automatic logic [7:0] stream_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  initial begin : stimulus
    int queued;
    int n;
    live_cfg.width = bpyc_pkg::RST_IMAGE_WIDTH;
    live_cfg.height = bpyc_pkg::RST_IMAGE_HEIGHT;
    live_cfg.bottom_up = bpyc_pkg::RST_BOTTOM_UP;
    live_cfg.is_32bit = bpyc_pkg::RST_PIXEL_32BIT;
    sender_idle_pct = 22;
    receiver_idle_pct = 87;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // 2x2 bottom-up 24-bit: black and white, row padding left pending
    apply_setting(13'd2, 13'd2, 1'b1, 1'b0, 4'b1111);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    settle();

    // 32-bit mode does not cancel the pending padding; stop before the last alpha
    apply_setting('0, '0, 1'b0, 1'b1, 4'b1000);
    pending_bytes.push_back(8'h5A);
    pending_bytes.push_back(8'hC3);
    push_pixel(8'hFF, 8'h00, 8'h00);
    pending_bytes.push_back(8'hA5);
    push_pixel(8'h00, 8'h00, 8'hFF);
    settle();

    // back to 24-bit with an alpha byte due; zero sizes act as 1x1, top-down
    apply_setting('0, '0, 1'b0, 1'b0, 4'b1111);
    pending_bytes.push_back(8'h81);
    push_pixel(8'h00, 8'hFF, 8'h00);
    pending_bytes.push_back(8'h7E);
    settle();
    queued = 20;

    // random phases, each closed by a full drain
    while (queued < ITEM_TARGET) begin
      if (queued < ITEM_TARGET / 3) begin
        sender_idle_pct = 22;
        receiver_idle_pct = 87;
      end else if (queued < 2 * ITEM_TARGET / 3) begin
        sender_idle_pct = 87;
        receiver_idle_pct = 22;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if ($urandom_range(0, 3) != 0)
        apply_setting(pick_dim(), pick_dim(), 1'($urandom), 1'($urandom), 4'($urandom));
      n = $urandom_range(10, 80);
      repeat (n) pending_bytes.push_back(stream_byte());
      queued += n;
      settle();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/bpyc_pkg.sv
rtl/core/bpyc_parse.sv
rtl/core/bpyc_conv.sv
rtl/core/bmp_pixel_to_ycbcr_unit.sv
test/tb_bmp_pixel_to_ycbcr_unit.sv
